### sv/pidf_pkg.sv
// Package for the filtered-derivative PID unit.
// Holds word types, register indexes, command codes, widths and saturating add and subtract helpers.
// No dependencies.
package pidf_pkg;

  localparam int SIG_W  = 32;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 64;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_DT    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KP    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KI    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KD    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TAU   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_LIMIT = 3'd5;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_LOAD1  = 2'd2;
  localparam logic [1:0] CMD_LOAD2  = 2'd3;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [SIG_W-1:0] setpoint;
    logic signed [SIG_W-1:0] measurement;
    logic signed [SIG_W-1:0] feedforward;
    logic signed [SIG_W-1:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SIG_W-1:0] drive;
    logic                    clamped;
  } out_word_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(
      input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/pidf_mul.sv
// Iterative fixed-point multiplier: four 32x32 partial products per operation.
// Floors the product by the fraction width and saturates to 64 bits.
// Depends on pidf_pkg.
module pidf_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [pidf_pkg::ACC_W-1:0]     op_a,
  input  logic signed [pidf_pkg::ACC_W-1:0]     op_b,
  output logic                                  done,
  output logic signed [pidf_pkg::ACC_W-1:0]     result
);

  localparam int W = pidf_pkg::ACC_W;
  localparam int H = W / 2;
  localparam int FRAC_SH = pidf_pkg::FRAC_W;

  logic               busy_r;
  logic               done_r;
  logic [2:0]         cnt_r;
  logic               neg_r;
  logic [W-1:0]       ua_r;
  logic [W-1:0]       ub_r;
  logic [W-1:0]       prod_r;
  logic [6:0]         sh_r;
  logic [2*W-1:0]     acc_r;
  logic signed [W-1:0] res_r;

  logic [H-1:0]       a_half;
  logic [H-1:0]       b_half;
  logic [6:0]         sh_nxt;
  logic               lost;
  logic [2*W-FRAC_SH-1:0] rnd;
  logic [2*W-FRAC_SH-1:0] lim;
  logic [2*W-FRAC_SH-1:0] mag;
  logic signed [W-1:0] fin;

  always_comb begin
    a_half = cnt_r[1] ? ua_r[W-1:H] : ua_r[H-1:0];
    b_half = cnt_r[0] ? ub_r[W-1:H] : ub_r[H-1:0];
    sh_nxt = {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0], 5'd0};
    lost   = |acc_r[FRAC_SH-1:0];
    rnd    = acc_r[2*W-1:FRAC_SH] + {{(2*W-FRAC_SH-1){1'b0}}, neg_r & lost};
    lim    = {{(W-FRAC_SH){1'b0}}, 1'b0, {(W-1){1'b1}}}
             + {{(2*W-FRAC_SH-1){1'b0}}, neg_r};
    mag    = (rnd > lim) ? lim : rnd;
    fin    = neg_r ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= op_a[W-1] ^ op_b[W-1];
        ua_r   <= op_a[W-1] ? W'(-op_a) : W'(op_a);
        ub_r   <= op_b[W-1] ? W'(-op_b) : W'(op_b);
        acc_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r < 3'd4) begin
          prod_r <= {{H{1'b0}}, a_half} * {{H{1'b0}}, b_half};
          sh_r   <= sh_nxt;
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
          acc_r <= acc_r + ({{W{1'b0}}, prod_r} << sh_r);
        end
        if (cnt_r == 3'd5) begin
          res_r  <= fin;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### sv/pidf_div.sv
// Restoring divider, one quotient bit per cycle.
// Computes trunc(n * 2^FRAC / d) for d > 0, saturated to 64 bits. Depends on pidf_pkg.
module pidf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pidf_pkg::ACC_W-1:0] num,
  input  logic [31:0]                       den,
  output logic                              done,
  output logic signed [pidf_pkg::ACC_W-1:0] result
);

  localparam int W  = pidf_pkg::ACC_W;
  localparam int DW = W + pidf_pkg::FRAC_W;

  logic                busy_r;
  logic                done_r;
  logic [6:0]          cnt_r;
  logic                neg_r;
  logic [DW-1:0]       dd_r;
  logic [31:0]         rem_r;
  logic [31:0]         den_r;
  logic signed [W-1:0] res_r;

  logic [32:0]         trial;
  logic                qbit;
  logic [DW-1:0]       lim;
  logic [DW-1:0]       mag;

  always_comb begin
    trial = {rem_r, dd_r[DW-1]};
    qbit  = trial >= {1'b0, den_r};
    lim   = {{(DW-W){1'b0}}, 1'b0, {(W-1){1'b1}}} + {{(DW-1){1'b0}}, neg_r};
    mag   = (dd_r > lim) ? lim : dd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= num[W-1];
        dd_r   <= {(num[W-1] ? W'(-num) : W'(num)), {pidf_pkg::FRAC_W{1'b0}}};
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (cnt_r == 7'(DW)) begin
          res_r  <= neg_r ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 7'd1;
          rem_r <= qbit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
          dd_r  <= {dd_r[DW-2:0], qbit};
        end
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### sv/pid_filtered_derivative_ff_unit.sv
// PID controller with low-pass filtered derivative, feed-forward and output clamp.
// Top level: sequencer, history and configuration. Uses pidf_pkg, pidf_mul, pidf_div.
//
// An update word after warm-up runs nine products on the shared multiplier, then a
// divide; during the first two updates after a clear or reset it runs a single product.
// Clear and load words are taken in the idle state without starting the sequencer.
// in_stall is high while a word is in progress or a result waits on a stalled output.
module pid_filtered_derivative_ff_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pidf_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pidf_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [pidf_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [pidf_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int W = pidf_pkg::ACC_W;
  localparam int S = pidf_pkg::SIG_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MWAIT, ST_DIV, ST_DWAIT, ST_OUT
  } state_t;

  state_t               state_r;
  logic [3:0]           step_r;
  logic [30:0]          dt_r, tau_r, lim_r;
  logic signed [31:0]   kp_r, ki_r, kd_r;
  logic signed [S-1:0]  pd_r, pd2_r, pe_r, pe2_r, e_r, ff_r;
  logic [1:0]           warm_r;
  logic signed [W-1:0]  kidt_r, c0_r, c1_r, num_r, u_r;
  logic                 out_valid_r;
  pidf_pkg::out_word_t  out_data_r;

  logic                 in_acc;
  logic signed [S:0]    diff;
  logic signed [S-1:0]  e_nxt;
  logic signed [W-1:0]  dt64, tau64, kp64, ki64, kd64, s64, ttd64, c2_64;
  logic signed [W-1:0]  op_a, op_b;
  logic                 mul_start, mul_done, div_start, div_done;
  logic signed [W-1:0]  mul_res, div_res;
  logic [31:0]          den;
  logic signed [W-1:0]  lim64, u_cl;
  logic                 cl;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    diff  = {in_data.setpoint[S-1], in_data.setpoint}
            - {in_data.measurement[S-1], in_data.measurement};
    if (diff[S] != diff[S-1]) begin
      e_nxt = diff[S] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end else begin
      e_nxt = diff[S-1:0];
    end
    dt64  = {33'd0, dt_r};
    tau64 = {33'd0, tau_r};
    kp64  = {{32{kp_r[31]}}, kp_r};
    ki64  = {{32{ki_r[31]}}, ki_r};
    kd64  = {{32{kd_r[31]}}, kd_r};
    s64   = dt64 + tau64;
    ttd64 = {32'd0, tau_r, 1'b0} + dt64;
    c2_64 = tau64 + kd64;
    den   = (s64[31:0] == 32'd0) ? 32'd1 : s64[31:0];
    case (step_r)
      4'd0: begin op_a = ki64; op_b = dt64; end
      4'd1: begin op_a = pidf_pkg::sat_add(kp64, kidt_r); op_b = s64; end
      4'd2: begin op_a = kp64; op_b = ttd64; end
      4'd3: begin op_a = kidt_r; op_b = tau64; end
      4'd4: begin op_a = tau64; op_b = {{(W-S){pd2_r[S-1]}}, pd2_r}; end
      4'd5: begin op_a = ttd64; op_b = {{(W-S){pd_r[S-1]}}, pd_r}; end
      4'd6: begin op_a = c0_r; op_b = {{(W-S){e_r[S-1]}}, e_r}; end
      4'd7: begin op_a = c1_r; op_b = {{(W-S){pe_r[S-1]}}, pe_r}; end
      4'd8: begin op_a = c2_64; op_b = {{(W-S){pe2_r[S-1]}}, pe2_r}; end
      default: begin op_a = kp64; op_b = {{(W-S){e_r[S-1]}}, e_r}; end
    endcase
    mul_start = (state_r == ST_MUL);
    div_start = (state_r == ST_DIV);
    lim64 = {33'd0, lim_r};
    cl    = 1'b0;
    u_cl  = u_r;
    if (u_r > lim64) begin
      u_cl = lim64;
      cl   = 1'b1;
    end else if (u_r < -lim64) begin
      u_cl = -lim64;
      cl   = 1'b1;
    end
  end

  pidf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (op_a),
    .op_b   (op_b),
    .done   (mul_done),
    .result (mul_res)
  );

  pidf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num_r),
    .den    (den),
    .done   (div_done),
    .result (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      dt_r        <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      tau_r       <= 31'd65536;
      lim_r       <= '1;
      pd_r        <= '0;
      pd2_r       <= '0;
      pe_r        <= '0;
      pe2_r       <= '0;
      warm_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_stall == 1'b0 && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          pidf_pkg::REG_DT:    dt_r  <= cfg_wdata[30:0];
          pidf_pkg::REG_KP:    kp_r  <= cfg_wdata;
          pidf_pkg::REG_KI:    ki_r  <= cfg_wdata;
          pidf_pkg::REG_KD:    kd_r  <= cfg_wdata;
          pidf_pkg::REG_TAU:   tau_r <= cfg_wdata[30:0];
          pidf_pkg::REG_LIMIT: lim_r <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_data.cmd)
              pidf_pkg::CMD_CLEAR: begin
                pd_r   <= '0;
                pd2_r  <= '0;
                pe_r   <= '0;
                pe2_r  <= '0;
                warm_r <= '0;
              end
              pidf_pkg::CMD_LOAD1: pd_r  <= in_data.load_value;
              pidf_pkg::CMD_LOAD2: pd2_r <= in_data.load_value;
              default: begin
                e_r  <= e_nxt;
                ff_r <= in_data.feedforward;
                if (warm_r < 2'd2) begin
                  warm_r <= warm_r + 2'd1;
                  step_r <= 4'd9;
                end else begin
                  step_r <= 4'd0;
                end
                state_r <= ST_MUL;
              end
            endcase
          end
        end
        ST_MUL: state_r <= ST_MWAIT;
        ST_MWAIT: begin
          if (mul_done) begin
            state_r <= ST_MUL;
            step_r  <= step_r + 4'd1;
            case (step_r)
              4'd0: kidt_r <= mul_res;
              4'd1: c0_r   <= pidf_pkg::sat_add(mul_res, kd64);
              4'd2: c1_r   <= mul_res;
              4'd3: c1_r   <= pidf_pkg::sat_add(pidf_pkg::sat_add(c1_r, mul_res),
                                                {kd64[W-2:0], 1'b0});
              4'd4: num_r  <= pidf_pkg::sat_sub('0, mul_res);
              4'd5: num_r  <= pidf_pkg::sat_add(num_r, mul_res);
              4'd6: num_r  <= pidf_pkg::sat_add(num_r, mul_res);
              4'd7: num_r  <= pidf_pkg::sat_sub(num_r, mul_res);
              4'd8: begin
                num_r   <= pidf_pkg::sat_add(num_r, mul_res);
                state_r <= ST_DIV;
              end
              default: begin
                u_r <= pidf_pkg::sat_add({{(W-S){ff_r[S-1]}}, ff_r}
                                         + {{(W-S){pd_r[S-1]}}, pd_r}, mul_res);
                state_r <= ST_OUT;
              end
            endcase
          end
        end
        ST_DIV: state_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            u_r     <= pidf_pkg::sat_add({{(W-S){ff_r[S-1]}}, ff_r}, div_res);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r        <= 1'b1;
            out_data_r.drive   <= u_cl[S-1:0];
            out_data_r.clamped <= cl;
            pd2_r   <= pd_r;
            pd_r    <= u_cl[S-1:0];
            pe2_r   <= pe_r;
            pe_r    <= e_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sim/pid_filtered_derivative_ff_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for pid_filtered_derivative_ff_unit: directed table, then random
// words under several register settings, checked against an in-bench controller predictor.
// Depends on pidf_pkg and the unit under test.
module pid_filtered_derivative_ff_unit_tb;

  localparam logic signed [127:0] WIDE_MAX = 128'sh7fffffffffffffff;
  localparam logic signed [127:0] WIDE_MIN = -128'sh8000000000000000;
  localparam longint SIG_MAX = 64'sd2147483647;
  localparam longint SIG_MIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    bit                  typed;
    pidf_pkg::out_word_t word;
  } drive_expect_t;

  typedef struct {
    pidf_pkg::in_word_t word;
    drive_expect_t      want;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pidf_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  pidf_pkg::out_word_t out_data;
  logic cfg_we;
  logic [pidf_pkg::CFG_AW-1:0] cfg_addr;
  logic [pidf_pkg::CFG_DW-1:0] cfg_wdata;

  longint dt_q, kp_q, ki_q, kd_q, tau_q, limit_q;
  longint drive_hist1, drive_hist2, err_hist1, err_hist2;
  int warm_cnt;
  int errors;
  int stuck_cycles;
  bit no_gaps;
  bit long_hold;
  pidf_pkg::out_word_t drive_q[$];
  drive_expect_t table_q[$];

  pid_filtered_derivative_ff_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clip64(logic signed [127:0] v);
    if (v > WIDE_MAX) return WIDE_MAX[63:0];
    if (v < WIDE_MIN) return WIDE_MIN[63:0];
    return v[63:0];
  endfunction

  function automatic longint clip_sig(longint v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clip64(x + y);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clip64(x - y);
  endfunction

  // Fixed-point product, floored, saturated to 64 bits.
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clip64((x * y) >>> pidf_pkg::FRAC_W);
  endfunction

  // Fixed-point quotient, truncated toward zero, saturated to 64 bits.
  function automatic longint fx_div(longint n, longint d);
    logic signed [127:0] x, y;
    x = n;
    y = d;
    x = x <<< pidf_pkg::FRAC_W;
    return clip64(x / y);
  endfunction

  function automatic pidf_pkg::out_word_t next_drive(pidf_pkg::in_word_t w);
    longint sp, ms, ff, err, u, s, tt, kidt, c0, c1, c2, acc;
    pidf_pkg::out_word_t r;
    sp = w.setpoint;
    ms = w.measurement;
    ff = w.feedforward;
    err = clip_sig(sp - ms);
    r.clamped = 1'b0;
    if (warm_cnt < 2) begin
      warm_cnt++;
      u = add_sat(add_sat(ff, drive_hist1), fx_mul(kp_q, err));
    end else begin
      s = dt_q + tau_q;
      tt = 2 * tau_q + dt_q;
      kidt = fx_mul(ki_q, dt_q);
      c0 = add_sat(fx_mul(add_sat(kp_q, kidt), s), kd_q);
      c1 = add_sat(add_sat(fx_mul(kp_q, tt), fx_mul(kidt, tau_q)), 2 * kd_q);
      c2 = tau_q + kd_q;
      acc = sub_sat(0, fx_mul(tau_q, drive_hist2));
      acc = add_sat(acc, fx_mul(tt, drive_hist1));
      acc = add_sat(acc, fx_mul(c0, err));
      acc = sub_sat(acc, fx_mul(c1, err_hist1));
      acc = add_sat(acc, fx_mul(c2, err_hist2));
      u = add_sat(ff, fx_div(acc, (s > 0) ? s : 64'sd1));
    end
    if (u > limit_q) begin
      u = limit_q;
      r.clamped = 1'b1;
    end
    if (u < -limit_q) begin
      u = -limit_q;
      r.clamped = 1'b1;
    end
    if (clip_sig(u) != u) begin
      u = clip_sig(u);
      r.clamped = 1'b1;
    end
    drive_hist2 = drive_hist1;
    drive_hist1 = u;
    err_hist2 = err_hist1;
    err_hist1 = err;
    r.drive = u[pidf_pkg::SIG_W-1:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    drive_expect_t tw;
    pidf_pkg::out_word_t p, e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tw = table_q.pop_front();
        case (in_data.cmd)
          pidf_pkg::CMD_UPDATE: begin
            p = next_drive(in_data);
            drive_q.push_back(tw.typed ? tw.word : p);
          end
          pidf_pkg::CMD_CLEAR: begin
            drive_hist1 = 0;
            drive_hist2 = 0;
            err_hist1 = 0;
            err_hist2 = 0;
            warm_cnt = 0;
          end
          pidf_pkg::CMD_LOAD1: drive_hist1 = in_data.load_value;
          pidf_pkg::CMD_LOAD2: drive_hist2 = in_data.load_value;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          report("unexpected word", out_data.drive, '0);
        end else begin
          e = drive_q.pop_front();
          if (out_data.drive !== e.drive) report("drive", out_data.drive, e.drive);
          if (out_data.clamped !== e.clamped) report("clamped", out_data.clamped, e.clamped);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
        $display("pid_filtered_derivative_ff_unit_tb: errors");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (long_hold) begin
        gap = 400;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  task automatic send_word(pidf_pkg::in_word_t w, drive_expect_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    table_q.push_back(want);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [pidf_pkg::CFG_AW-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[31:0];
    case (idx)
      pidf_pkg::REG_DT:    dt_q = val & 64'h7fffffff;
      pidf_pkg::REG_KP:    kp_q = longint'($signed(val[31:0]));
      pidf_pkg::REG_KI:    ki_q = longint'($signed(val[31:0]));
      pidf_pkg::REG_KD:    kd_q = longint'($signed(val[31:0]));
      pidf_pkg::REG_TAU:   tau_q = val & 64'h7fffffff;
      pidf_pkg::REG_LIMIT: limit_q = val & 64'h7fffffff;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic logic [31:0] sig_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 13107200) - 6553600;
  endfunction

  function automatic logic [31:0] gain_value();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 524288) - 262144;
  endfunction

  function automatic pidf_pkg::in_word_t row(logic [1:0] c, longint sp, longint ms,
                                             longint ff, longint lv);
    pidf_pkg::in_word_t w;
    w.cmd = c;
    w.setpoint = sp[31:0];
    w.measurement = ms[31:0];
    w.feedforward = ff[31:0];
    w.load_value = lv[31:0];
    return w;
  endfunction

  function automatic drive_expect_t typed(longint d, bit c);
    drive_expect_t t;
    t.typed = 1'b1;
    t.word.drive = d[31:0];
    t.word.clamped = c;
    return t;
  endfunction

  initial begin
    table_row_t rows[$];
    drive_expect_t open_want;
    pidf_pkg::in_word_t w;
    int pick;
    errors = 0;
    stuck_cycles = 0;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    open_want.typed = 1'b0;
    open_want.word = '0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    dt_q = 0;
    kp_q = 0;
    ki_q = 0;
    kd_q = 0;
    tau_q = 65536;
    limit_q = SIG_MAX;
    drive_hist1 = 0;
    drive_hist2 = 0;
    err_hist1 = 0;
    err_hist2 = 0;
    warm_cnt = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows.push_back('{row(pidf_pkg::CMD_UPDATE, 0, 0, 5, 0), typed(5, 0)});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, 0, 0, SIG_MAX, 0), typed(SIG_MAX, 1)});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, 3, -9, 7, 0), open_want});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, SIG_MAX, SIG_MIN, SIG_MIN, 0), open_want});
    rows.push_back('{row(pidf_pkg::CMD_CLEAR, 0, 0, 0, 0), open_want});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, SIG_MIN, SIG_MAX, SIG_MIN, 0),
                     typed(-SIG_MAX, 1)});
    rows.push_back('{row(pidf_pkg::CMD_CLEAR, 0, 0, 0, 0), open_want});
    rows.push_back('{row(pidf_pkg::CMD_LOAD1, 0, 0, 0, 1234), open_want});
    rows.push_back('{row(pidf_pkg::CMD_LOAD2, 0, 0, 0, -77), open_want});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, 0, 0, 0, 0), typed(1234, 0)});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, SIG_MAX, SIG_MIN, 0, 0), typed(1234, 0)});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, 100, 40, -3, 0), open_want});
    rows.push_back('{row(pidf_pkg::CMD_LOAD1, 0, 0, 0, SIG_MAX), open_want});
    rows.push_back('{row(pidf_pkg::CMD_LOAD2, 0, 0, 0, SIG_MIN), open_want});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, SIG_MIN, SIG_MAX, SIG_MAX, SIG_MIN),
                     open_want});
    rows.push_back('{row(pidf_pkg::CMD_UPDATE, -1, -1, -1, -1), open_want});
    foreach (rows[i]) send_word(rows[i].word, rows[i].want);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(pidf_pkg::REG_DT, 655);
          write_reg(pidf_pkg::REG_KP, 65536);
          write_reg(pidf_pkg::REG_KI, 32768);
          write_reg(pidf_pkg::REG_KD, 1000);
          write_reg(pidf_pkg::REG_TAU, 6554);
          write_reg(pidf_pkg::REG_LIMIT, 50 * 65536);
        end
        1: begin
          write_reg(pidf_pkg::REG_DT, 64'h7fffffff);
          write_reg(pidf_pkg::REG_KP, 64'h7fffffff);
          write_reg(pidf_pkg::REG_KI, 64'h80000000);
          write_reg(pidf_pkg::REG_KD, 64'h7fffffff);
          write_reg(pidf_pkg::REG_TAU, 64'h7fffffff);
          write_reg(pidf_pkg::REG_LIMIT, 64'h7fffffff);
        end
        2: begin
          write_reg(pidf_pkg::REG_DT, 0);
          write_reg(pidf_pkg::REG_KP, 64'h80000000);
          write_reg(pidf_pkg::REG_KI, 0);
          write_reg(pidf_pkg::REG_KD, 64'h80000000);
          write_reg(pidf_pkg::REG_TAU, 1);
          write_reg(pidf_pkg::REG_LIMIT, 0);
        end
        default: begin
          write_reg(pidf_pkg::REG_DT, $urandom_range(1, 65536));
          write_reg(pidf_pkg::REG_KP, gain_value());
          write_reg(pidf_pkg::REG_KI, gain_value());
          write_reg(pidf_pkg::REG_KD, gain_value());
          write_reg(pidf_pkg::REG_TAU, $urandom_range(1, 131072));
          write_reg(pidf_pkg::REG_LIMIT,
                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 8000000));
        end
      endcase
      no_gaps = (ph == 4);
      if (ph == 3) long_hold = 1'b1;
      for (int n = 0; n < 210; n++) begin
        pick = $urandom_range(0, 99);
        w.cmd = pick < 85 ? pidf_pkg::CMD_UPDATE : pick < 90 ? pidf_pkg::CMD_CLEAR :
                pick < 95 ? pidf_pkg::CMD_LOAD1 : pidf_pkg::CMD_LOAD2;
        w.setpoint = sig_value();
        w.measurement = sig_value();
        w.feedforward = sig_value();
        w.load_value = sig_value();
        send_word(w, open_want);
      end
    end
    no_gaps = 1'b0;
    settle();
    if (errors == 0) begin
      $display("pid_filtered_derivative_ff_unit_tb: clean");
    end else begin
      $display("pid_filtered_derivative_ff_unit_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/pidf_pkg.sv
sv/pidf_mul.sv
sv/pidf_div.sv
sv/pid_filtered_derivative_ff_unit.sv
sim/pid_filtered_derivative_ff_unit_tb.sv
